// ===== rtl/core/lzce_pkg.sv =====
// Shared types, constants and helper functions of the Laplacian zero-crossing edge detector.
`default_nettype none

package lzce_pkg;

	// Defaults of the frame size limits.
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	// Field and register widths.
	localparam int PIX_W  = 8;
	localparam int LAP_W  = 12;
	localparam int THR_W  = 12;
	localparam int DIM_W  = 11;
	localparam int IDX_W  = 2;
	localparam int CFG_W  = 12;
	localparam int EDGE_W = 8;
	localparam int POS_W  = 10;

	// Size registers come out of reset at this value before clamping.
	localparam int DIM_RESET = 1024;
	localparam int DIM_MIN   = 3;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [IDX_W-1:0] CFG_WIDTH     = 2'd1;
	localparam logic [IDX_W-1:0] CFG_HEIGHT    = 2'd2;

	// Input word operation codes.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// Result codes.
	localparam logic [EDGE_W-1:0] EDGE_ON  = 8'd255;
	localparam logic [EDGE_W-1:0] EDGE_OFF = 8'd0;

	typedef logic signed [LAP_W-1:0] lap_t;

	// Per-word control that travels down the pipeline.
	typedef struct packed {
		logic valid;    // a word of the frame occupies this stage
		logic wr_pix;   // the word carries a pixel to store
		logic q_valid;  // a Laplacian position is computed for this word
		logic q_int;    // that position is interior
		logic p_valid;  // a result is produced for this word
		logic p_int;    // the result position is interior
		logic p_last;   // the result position closes the frame
	} ctl_t;

	// True when the two values have strictly opposite signs.
	function automatic logic lap_opposite(lap_t a, lap_t b);
		return ((a > 0) && (b < 0)) || ((a < 0) && (b > 0));
	endfunction

	// True when the magnitude of the difference is above the threshold.
	function automatic logic lap_exceeds(lap_t a, lap_t b, logic [THR_W-1:0] thr);
		logic [LAP_W:0]   diff;
		logic [LAP_W:0]   neg;
		logic [LAP_W-1:0] mag;
		diff = {a[LAP_W-1], a} - {b[LAP_W-1], b};
		neg  = ~diff + (LAP_W+1)'(1);
		mag  = diff[LAP_W] ? neg[LAP_W-1:0] : diff[LAP_W-1:0];
		return mag > thr;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/laplacian_zero_crossing_edges.sv =====
// Top level of the streaming 3x3 Laplacian zero-crossing edge detector.
`default_nettype none

// Usage:
// Pixel words (op, pixel) enter on the pix_valid / pix_ready channel in raster order,
// already gray and blurred. Result words (edge_res, row, col, last) leave on the
// res_valid / res_ready channel, one per frame position, in raster order.
// The result of a position is caused by the word 2*width+2 positions later in the
// frame; after the last pixel the host sends flush words to drain the tail. A flush
// word sent before the frame's pixels are complete is taken and dropped.
// Each caused result passes stages s1, s2, s3 and the output register on its way
// out. The block accepts one word per cycle while pix_ready is high: the two line
// memories are each read once and written once per word; no other unit is shared.
// A stalled receiver stops the pipeline only while a result waits in the output
// register and the next result is ready behind it; pix_ready then drops.
// Configuration is written through cfg_write / cfg_index / cfg_wdata while no word is
// in flight. Writing the width or the height restarts the frame; sizes are clamped
// to the range 3 up to the maximum.
// Reset clears the frame position, the pipeline and the output register and loads
// threshold 0 and the maximum frame size. The line memories need no clearing: every
// entry is written in a frame before that frame reads it.
module laplacian_zero_crossing_edges
	import lzce_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               cfg_write,
	input  wire logic [IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_wdata,

	input  wire logic               pix_valid,
	output logic                    pix_ready,
	input  wire logic               op,
	input  wire logic [PIX_W-1:0]   pixel,

	output logic                    res_valid,
	input  wire logic               res_ready,
	output logic [EDGE_W-1:0]       edge_res,
	output logic [POS_W-1:0]        row,
	output logic [POS_W-1:0]        col,
	output logic                    last
);

	// Column counter, width value, row counter (runs up to height+2 during the drain).
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 3);
	localparam int W_RST = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
	localparam int H_RST = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

	// Configuration registers, sizes stored already clamped.
	logic [THR_W-1:0] thr_q;
	logic [WW-1:0]    w_q;
	logic [RW-1:0]    h_q;
	logic [DIM_W-1:0] dim;
	logic [WW-1:0]    w_new;
	logic [RW-1:0]    h_new;
	logic             restart;

	// Frame position of the next word.
	logic [RW-1:0] in_row_q;
	logic [CW-1:0] in_col_q;

	// Position decode of the word at the input.
	logic [CW-1:0] wm1;
	logic [RW-1:0] hm1;
	logic          in_pix;
	logic          col_zero;
	logic          q_ok;
	logic [RW-1:0] q_row;
	logic [CW-1:0] q_col;
	logic          p_ok;
	logic [RW-1:0] p_row;
	logic [CW-1:0] p_col;
	ctl_t          ctl0;
	logic          take;
	logic          adv;

	// Pipeline.
	ctl_t             ctl_s1, ctl_s2, ctl_s3;
	logic [PIX_W-1:0] pix_s1;
	logic [CW-1:0]    col_s1;
	logic [CW-1:0]    q_col_s1, q_col_s2, q_col_s3;
	logic [RW-1:0]    p_row_s1, p_row_s2, p_row_s3;
	logic [CW-1:0]    p_col_s1, p_col_s2, p_col_s3;
	lap_t             lap_s3;

	// Line memories: each word holds the two rows above the current one at a column,
	// the newer row in the upper half.
	logic [2*PIX_W-1:0] pix_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] pix_rd_q;
	logic [2*LAP_W-1:0] lap_mem [MAX_WIDTH];
	logic [2*LAP_W-1:0] lap_rd_q;

	// 3x3 pixel window, indexed [column][row], row 2 the newest.
	logic [PIX_W-1:0] pw_q [3][3];
	logic [LAP_W-1:0] nb_sum;
	logic [LAP_W-1:0] lap_calc;

	// Laplacian neighborhood of the result position.
	lap_t lw_w_q, lw_c_q, lw_n_q, lw_s_q;
	lap_t lap_east;
	logic any_opp;
	logic any_exc;
	logic edge_s3;

	// Output register.
	logic              res_valid_q;
	logic [EDGE_W-1:0] res_edge_q;
	logic [POS_W-1:0]  res_row_q;
	logic [POS_W-1:0]  res_col_q;
	logic              res_last_q;
	logic              hold;

	// ------------------------------------------------------------------
	// Configuration.
	// ------------------------------------------------------------------
	always_comb begin
		dim = cfg_wdata[DIM_W-1:0];
		if (int'(dim) < DIM_MIN) begin
			w_new = WW'(DIM_MIN);
		end else if (int'(dim) > MAX_WIDTH) begin
			w_new = WW'(MAX_WIDTH);
		end else begin
			w_new = WW'(dim);
		end
		if (int'(dim) < DIM_MIN) begin
			h_new = RW'(DIM_MIN);
		end else if (int'(dim) > MAX_HEIGHT) begin
			h_new = RW'(MAX_HEIGHT);
		end else begin
			h_new = RW'(dim);
		end
	end

	assign restart = cfg_write && ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			w_q   <= WW'(W_RST);
			h_q   <= RW'(H_RST);
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_THRESHOLD: thr_q <= cfg_wdata[THR_W-1:0];
				CFG_WIDTH:     w_q   <= w_new;
				CFG_HEIGHT:    h_q   <= h_new;
				default:       ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input position decode. The Laplacian position lags the input by
	// width+1 words, the result position by 2*width+2 words.
	// ------------------------------------------------------------------
	assign wm1 = CW'(w_q - WW'(1));
	assign hm1 = h_q - RW'(1);

	always_comb begin
		in_pix   = in_row_q < h_q;
		col_zero = in_col_q == '0;

		// One row and one column back.
		q_ok  = col_zero ? (in_row_q >= RW'(2)) : (in_row_q != '0);
		q_row = col_zero ? (in_row_q - RW'(2)) : (in_row_q - RW'(1));
		q_col = col_zero ? wm1 : (in_col_q - CW'(1));

		// One row and one column back again.
		p_ok  = q_ok && ((q_col == '0) ? (q_row >= RW'(2)) : (q_row != '0));
		p_row = (q_col == '0) ? (q_row - RW'(2)) : (q_row - RW'(1));
		p_col = (q_col == '0) ? wm1 : (q_col - CW'(1));

		ctl0.valid   = 1'b1;
		ctl0.wr_pix  = in_pix;
		ctl0.q_valid = q_ok && (q_row < h_q);
		ctl0.q_int   = (q_row != '0) && (q_row < hm1) && (q_col != '0) && (q_col < wm1);
		ctl0.p_valid = p_ok && (p_row < h_q);
		ctl0.p_int   = (p_row != '0) && (p_row < hm1) && (p_col != '0) && (p_col < wm1);
		ctl0.p_last  = (p_row == hm1) && (p_col == wm1);
	end

	// The pipeline moves unless a result is blocked behind a full output register.
	assign hold      = res_valid_q && !res_ready && ctl_s3.valid && ctl_s3.p_valid;
	assign adv       = !hold;
	assign pix_ready = adv;

	// A flush word that arrives before the frame's pixels are in is dropped.
	assign take = pix_valid && adv && !(in_pix && (op == OP_FLUSH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q <= '0;
			in_col_q <= '0;
		end else if (restart) begin
			in_row_q <= '0;
			in_col_q <= '0;
		end else if (take) begin
			if (ctl0.p_valid && ctl0.p_last) begin
				in_row_q <= '0;
				in_col_q <= '0;
			end else if (in_col_q == wm1) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + RW'(1);
			end else begin
				in_col_q <= in_col_q + CW'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s1 <= take ? ctl0 : '0;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1   <= pixel;
			col_s1   <= in_col_q;
			q_col_s1 <= q_col;
			p_row_s1 <= p_row;
			p_col_s1 <= p_col;
			q_col_s2 <= q_col_s1;
			p_row_s2 <= p_row_s1;
			p_col_s2 <= p_col_s1;
			q_col_s3 <= q_col_s2;
			p_row_s3 <= p_row_s2;
			p_col_s3 <= p_col_s2;
			lap_s3   <= ctl_s2.q_int ? lap_t'(lap_calc) : lap_t'(0);
		end
	end

	// ------------------------------------------------------------------
	// Pixel line memory: read at accept, written back one stage later with
	// the current pixel on top and the older row shifted down.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv) begin
			pix_rd_q <= pix_mem[in_col_q];
		end
		if (adv && ctl_s1.valid && ctl_s1.wr_pix) begin
			pix_mem[col_s1] <= {pix_s1, pix_rd_q[2*PIX_W-1:PIX_W]};
		end
	end

	// The window takes in the column of rows R-2, R-1 and R at the word's column.
	always_ff @(posedge clk) begin
		if (adv && ctl_s1.valid) begin
			for (int ri = 0; ri < 3; ri++) begin
				pw_q[0][ri] <= pw_q[1][ri];
				pw_q[1][ri] <= pw_q[2][ri];
			end
			pw_q[2][0] <= pix_rd_q[PIX_W-1:0];
			pw_q[2][1] <= pix_rd_q[2*PIX_W-1:PIX_W];
			pw_q[2][2] <= pix_s1;
		end
	end

	// Laplacian: eight times the center less the eight neighbors.
	always_comb begin
		nb_sum = '0;
		for (int ci = 0; ci < 3; ci++) begin
			for (int ri = 0; ri < 3; ri++) begin
				if (!((ci == 1) && (ri == 1))) begin
					nb_sum = nb_sum + LAP_W'(pw_q[ci][ri]);
				end
			end
		end
		lap_calc = {1'b0, pw_q[1][1], 3'b000} - nb_sum;
	end

	// ------------------------------------------------------------------
	// Laplacian line memory: read in the second stage, written back in the
	// third once the new value is known.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (adv) begin
			lap_rd_q <= lap_mem[q_col_s2];
		end
		if (adv && ctl_s3.valid && ctl_s3.q_valid) begin
			lap_mem[q_col_s3] <= {lap_s3, lap_rd_q[2*LAP_W-1:LAP_W]};
		end
	end

	// The result center sits one column behind the newest Laplacian column;
	// its east neighbor comes straight from the memory read.
	assign lap_east = lap_t'(lap_rd_q[2*LAP_W-1:LAP_W]);

	always_ff @(posedge clk) begin
		if (adv && ctl_s3.valid) begin
			lw_w_q <= lw_c_q;
			lw_c_q <= lap_east;
			lw_n_q <= lap_t'(lap_rd_q[LAP_W-1:0]);
			lw_s_q <= lap_s3;
		end
	end

	always_comb begin
		any_opp = lap_opposite(lw_c_q, lw_n_q) || lap_opposite(lw_c_q, lw_s_q) ||
			lap_opposite(lw_c_q, lap_east) || lap_opposite(lw_c_q, lw_w_q);
		any_exc = lap_exceeds(lw_c_q, lw_n_q, thr_q) || lap_exceeds(lw_c_q, lw_s_q, thr_q) ||
			lap_exceeds(lw_c_q, lap_east, thr_q) || lap_exceeds(lw_c_q, lw_w_q, thr_q);
		edge_s3 = ctl_s3.p_int && any_opp && any_exc;
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && ctl_s3.valid && ctl_s3.p_valid) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s3.valid && ctl_s3.p_valid) begin
			res_edge_q <= edge_s3 ? EDGE_ON : EDGE_OFF;
			res_row_q  <= POS_W'(p_row_s3);
			res_col_q  <= POS_W'(p_col_s3);
			res_last_q <= ctl_s3.p_last;
		end
	end

	assign res_valid = res_valid_q;
	assign edge_res  = res_edge_q;
	assign row       = res_row_q;
	assign col       = res_col_q;
	assign last      = res_last_q;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench of the streaming 3x3 Laplacian zero-crossing edge detector.
`timescale 1ns / 1ps

module testbench
	import lzce_pkg::*;
();

	// Frame store dimensions follow the default build of the block.
	localparam int MAX_W = DEF_MAX_WIDTH;
	localparam int MAX_H = DEF_MAX_HEIGHT;

	// Words that cause no result can still be in the pipeline once the last result is
	// out, so every idle point lets a few more cycles pass before the registers are
	// touched.
	localparam int DRAIN_CYCLES = 16;

	// Length of the long receiver hold-off, in cycles.
	localparam int LONG_HOLD = 300;

	// Hard stop for the whole run, several times the slowest legal run.
	localparam int TIMEOUT_NS = 400_000;

	localparam logic [THR_W-1:0] THR_MAX = '1;

	// One word on the pixel channel.
	typedef struct {
		logic             op_f;
		logic [PIX_W-1:0] pix_f;
	} in_word_t;

	// One word on the result channel.
	typedef struct {
		logic [EDGE_W-1:0] edge_v;
		logic [POS_W-1:0]  row_v;
		logic [POS_W-1:0]  col_v;
		logic              last_v;
	} edge_word_t;

	// Every input starts at a known value; reset is held from time zero.
	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_write = 1'b0;
	logic [IDX_W-1:0]   cfg_index = CFG_THRESHOLD;
	logic [CFG_W-1:0]   cfg_wdata = '0;
	logic               pix_valid = 1'b0;
	logic               op        = OP_PIXEL;
	logic [PIX_W-1:0]   pixel     = '0;
	logic               res_ready = 1'b0;
	logic               pix_ready;
	logic               res_valid;
	logic [EDGE_W-1:0]  edge_res;
	logic [POS_W-1:0]   row;
	logic [POS_W-1:0]   col;
	logic               last;

	laplacian_zero_crossing_edges DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.op        (op),
		.pixel     (pixel),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.edge_res  (edge_res),
		.row       (row),
		.col       (col),
		.last      (last)
	);

	always #4 clk = ~clk;

	// Words waiting to be offered, and edge words the block still owes us.
	in_word_t   pixel_words[$];
	edge_word_t expected_edges[$];

	// Handshake bookkeeping and the idling profile of the current phase.
	logic word_taken    = 1'b0;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	bit   long_hold_req  = 1'b0;
	int   hold_left      = 0;
	int   error_count    = 0;

	// Shadow of the detector: the three-row pixel ring, the three-row Laplacian
	// ring, the position inside the frame and the register contents.
	logic [PIX_W-1:0] pix_lines [3][MAX_W];
	lap_t             lap_lines [3][MAX_W];
	int unsigned      frame_pos      = 0;
	logic [THR_W-1:0] thr_setting    = '0;
	logic [DIM_W-1:0] width_setting  = DIM_W'(DIM_RESET);
	logic [DIM_W-1:0] height_setting = DIM_W'(DIM_RESET);

	// Sizes outside the supported range are pulled to the nearest legal value.
	function automatic int unsigned dim_in_use(logic [DIM_W-1:0] v, int unsigned hi);
		if (v < DIM_MIN)
			return DIM_MIN;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// A zero on either side never counts as a crossing.
	function automatic bit signs_cross(int a, int b);
		return (a > 0 && b < 0) || (a < 0 && b > 0);
	endfunction

	function automatic bit step_beyond(int a, int b);
		int d;
		d = a - b;
		if (d < 0)
			d = -d;
		return d > int'(thr_setting);
	endfunction

	// Advances the shadow by one accepted word and queues the edge word it causes.
	// The pixel is stored first, then the Laplacian one row and one column behind
	// is formed, then the edge decision two rows and two columns behind is made.
	function automatic void predict_edge_word(logic op_in, logic [PIX_W-1:0] pix_in);
		int unsigned w, h, total, n, q, p, r, c, dr, dc;
		int sum, mid, north, south, east, west;
		lap_t lap;
		edge_word_t res;
		w = dim_in_use(width_setting, MAX_W);
		h = dim_in_use(height_setting, MAX_H);
		total = w * h;
		n = frame_pos;

		// While the frame still lacks pixels a flush is dropped without a trace.
		if (n < total) begin
			if (op_in == OP_FLUSH)
				return;
			pix_lines[(n / w) % 3][n % w] = pix_in;
		end

		if (n >= w + 1 && n - w - 1 < total) begin
			q = n - w - 1;
			r = q / w;
			c = q % w;
			lap = '0;
			if (r >= 1 && r + 1 < h && c >= 1 && c + 1 < w) begin
				sum = 0;
				for (dr = 0; dr < 3; dr++)
					for (dc = 0; dc < 3; dc++)
						sum += int'(pix_lines[(r - 1 + dr) % 3][c - 1 + dc]);
				lap = lap_t'(9 * int'(pix_lines[r % 3][c]) - sum);
			end
			lap_lines[r % 3][c] = lap;
		end

		if (n >= 2 * w + 2 && n - 2 * w - 2 < total) begin
			p = n - 2 * w - 2;
			r = p / w;
			c = p % w;
			res.edge_v = EDGE_OFF;
			if (r >= 1 && r + 1 < h && c >= 1 && c + 1 < w) begin
				mid   = lap_lines[r % 3][c];
				north = lap_lines[(r - 1) % 3][c];
				south = lap_lines[(r + 1) % 3][c];
				east  = lap_lines[r % 3][c + 1];
				west  = lap_lines[r % 3][c - 1];
				if ((signs_cross(mid, north) || signs_cross(mid, south) ||
				     signs_cross(mid, east) || signs_cross(mid, west)) &&
				    (step_beyond(mid, north) || step_beyond(mid, south) ||
				     step_beyond(mid, east) || step_beyond(mid, west)))
					res.edge_v = EDGE_ON;
			end
			res.row_v  = POS_W'(r);
			res.col_v  = POS_W'(c);
			res.last_v = (p + 1 == total);
			expected_edges.push_back(res);
			// The word that reports the final position closes the frame.
			if (p + 1 == total) begin
				frame_pos = 0;
				return;
			end
		end
		frame_pos = n + 1;
	endfunction

	// Prints one line per mismatch and counts every one of them.
	task automatic report_mismatch(input string what, input int got, input int want);
		error_count++;
		$display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
	endtask

	// Register writes happen only while the block is idle, so the shadow can be
	// updated as soon as the write is driven. A size write restarts the frame.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			CFG_THRESHOLD: thr_setting = data[THR_W-1:0];
			CFG_WIDTH: begin
				width_setting = data[DIM_W-1:0];
				frame_pos = 0;
			end
			CFG_HEIGHT: begin
				height_setting = data[DIM_W-1:0];
				frame_pos = 0;
			end
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic push_word(input logic op_in, input logic [PIX_W-1:0] pix_in);
		in_word_t w;
		w.op_f  = op_in;
		w.pix_f = pix_in;
		pixel_words.push_back(w);
	endtask

	// Waits until every queued word is taken and every owed edge word has come,
	// then lets the pipeline settle. Polling at the rising edge sees the valid that
	// the driver set at the last falling edge, so a word about to go out is not missed.
	task automatic wait_for_drain();
		do
			@(posedge clk);
		while (pixel_words.size() != 0 || pix_valid || expected_edges.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Runs one frame at the given raw sizes. Most frames are complete and drained
	// with 2*width+2 trailing words, some of which are surplus pixels. A few are cut
	// short and left behind; the size write of the next frame restarts it. Early
	// flushes are sprinkled among the pixels and must be dropped.
	task automatic run_frame(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw,
	                         input bit may_abort, output int unsigned sent);
		int unsigned w, h, n_pix, pause_at, k, r, c, style;
		logic [PIX_W-1:0] v;
		sent = 0;
		write_reg(CFG_WIDTH, CFG_W'(w_raw));
		write_reg(CFG_HEIGHT, CFG_W'(h_raw));
		w = dim_in_use(w_raw, MAX_W);
		h = dim_in_use(h_raw, MAX_H);
		n_pix = w * h;
		if (may_abort && $urandom_range(9) == 0)
			n_pix = $urandom_range(n_pix - 1, 1);
		// Now and then the sender stops mid-frame until the block owes nothing.
		pause_at = ($urandom_range(5) == 0) ? $urandom_range(n_pix, 1) : 0;
		style = $urandom_range(3);
		for (k = 0; k < n_pix; k++) begin
			r = k / w;
			c = k % w;
			if ($urandom_range(19) == 0)
				push_word(OP_FLUSH, PIX_W'($urandom_range(255)));
			case (style)
				0: v = PIX_W'($urandom_range(255));
				1: v = $urandom_range(1) ? 8'd255 : 8'd0;
				// Blocks of bright and dark give clean crossings of varied strength.
				2: v = (((r >> 1) + (c >> 1)) % 2 == 1) ? PIX_W'($urandom_range(255, 190))
				                                         : PIX_W'($urandom_range(60));
				// A ramp keeps most Laplacians at zero, with jumps where it wraps.
				default: v = PIX_W'(r * 29 + c * 17);
			endcase
			push_word(OP_PIXEL, v);
			sent++;
			if (k + 1 == pause_at)
				wait_for_drain();
		end
		if (n_pix == w * h)
			for (k = 0; k < 2 * w + 2; k++) begin
				push_word(($urandom_range(4) == 0) ? OP_PIXEL : OP_FLUSH,
				          PIX_W'($urandom_range(255)));
				sent++;
			end
		wait_for_drain();
	endtask

	// Driver: offers the next word at the falling edge once the previous one was
	// taken. Valid stays up with a steady payload until the word is accepted, and
	// every step makes at most one assignment to each signal.
	always @(negedge clk) begin : drive_words
		in_word_t nxt;
		if (arst_n && (!pix_valid || word_taken)) begin
			if (pixel_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = pixel_words.pop_front();
				pix_valid <= 1'b1;
				op        <= nxt.op_f;
				pixel     <= nxt.pix_f;
			end else begin
				pix_valid <= 1'b0;
			end
		end
	end

	// Receiver: stalls at random, and on request holds off for a long stretch so
	// that the block backs up and drops pix_ready while words keep coming.
	always @(negedge clk) begin
		if (long_hold_req) begin
			hold_left     = LONG_HOLD;
			long_hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: at each rising edge an accepted pixel-channel word advances the
	// shadow, and an accepted result word is checked against the oldest expectation.
	always @(posedge clk) begin : watch_ports
		edge_word_t want;
		word_taken <= pix_valid && pix_ready;
		if (arst_n) begin
			if (pix_valid && pix_ready)
				predict_edge_word(op, pixel);
			if (res_valid && res_ready) begin
				if (expected_edges.size() == 0) begin
					report_mismatch("result word with none owed, col", col, -1);
				end else begin
					want = expected_edges.pop_front();
					if (edge_res !== want.edge_v)
						report_mismatch("edge_res", edge_res, want.edge_v);
					if (row !== want.row_v)
						report_mismatch("row", row, want.row_v);
					if (col !== want.col_v)
						report_mismatch("col", col, want.col_v);
					if (last !== want.last_v)
						report_mismatch("last", last, want.last_v);
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned frame_no, small_words, sent;
		logic [DIM_W-1:0] w_raw, h_raw;
		logic [THR_W-1:0] thr;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: a 3x3 frame cut short after five pixels, too few to owe any
		// result, then restarted by a width write with the threshold at its top.
		write_reg(CFG_THRESHOLD, '0);
		write_reg(CFG_WIDTH, CFG_W'(3));
		write_reg(CFG_HEIGHT, CFG_W'(3));
		push_word(OP_PIXEL, 8'd255);
		push_word(OP_PIXEL, 8'd0);
		push_word(OP_PIXEL, 8'd128);
		push_word(OP_PIXEL, 8'd1);
		push_word(OP_PIXEL, 8'd254);
		wait_for_drain();
		write_reg(CFG_THRESHOLD, CFG_W'(THR_MAX));
		write_reg(CFG_WIDTH, CFG_W'(3));

		// Full 3x3 frame opened by an early flush, pixels at both extremes, and a
		// surplus pixel among the trailing flushes.
		push_word(OP_FLUSH, 8'd255);
		push_word(OP_PIXEL, 8'd0);
		push_word(OP_PIXEL, 8'd255);
		push_word(OP_PIXEL, 8'd0);
		push_word(OP_PIXEL, 8'd255);
		push_word(OP_PIXEL, 8'd255);
		push_word(OP_PIXEL, 8'd255);
		push_word(OP_PIXEL, 8'd0);
		push_word(OP_PIXEL, 8'd255);
		push_word(OP_PIXEL, 8'd0);
		repeat (4) push_word(OP_FLUSH, 8'd0);
		push_word(OP_PIXEL, 8'd170);
		repeat (3) push_word(OP_FLUSH, 8'd85);
		wait_for_drain();

		// Random frames. The idling profile rotates per frame, and the sizes include
		// raw values below the smallest legal one.
		frame_no = 0;
		small_words = 0;
		while (small_words < 750 || frame_no < 14) begin
			case (frame_no % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			if (frame_no == 2 || frame_no == 8)
				long_hold_req = 1'b1;

			if (frame_no == 0 || $urandom_range(1) == 0) begin
				case ($urandom_range(4))
					0: thr = '0;
					1: thr = THR_MAX;
					2: thr = THR_W'($urandom_range(4095));
					default: thr = THR_W'($urandom_range(250));
				endcase
				write_reg(CFG_THRESHOLD, CFG_W'(thr));
			end

			case ($urandom_range(7))
				0: w_raw = DIM_W'($urandom_range(2));
				1: w_raw = DIM_W'($urandom_range(40, 16));
				default: w_raw = DIM_W'($urandom_range(10, 3));
			endcase
			h_raw = ($urandom_range(7) == 0) ? DIM_W'($urandom_range(2))
			                                 : DIM_W'($urandom_range(8, 3));
			run_frame(w_raw, h_raw, 1'b1, sent);
			small_words += sent;
			frame_no++;
		end

		// Every frame ends with a full drain, so nothing is owed at this point.
		wait_for_drain();
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Regression FAIL");
		$finish;
	end

endmodule
